// ===== rtl/tshm_pkg.sv =====
// Shared types, constants and helper functions of the two-stage hotkey matcher.
`timescale 1ns / 1ps

package tshm_pkg;

    // Default number of hotkey table entries.
    localparam int TABLE_DEPTH = 16;

    // Field widths.
    localparam int KEY_W  = 8;
    localparam int MODS_W = 4;
    localparam int HNDL_W = 8;
    localparam int REG_W  = 16;
    localparam int IDX_W  = 3;

    // Register values after reset.
    localparam logic [REG_W-1:0] SHIFT_CODES_RST  = 16'd15922;
    localparam logic [REG_W-1:0] CTRL_CODES_RST   = 16'd26917;
    localparam logic [REG_W-1:0] ALT_CODES_RST    = 16'd27712;
    localparam logic [REG_W-1:0] META_CODES_RST   = 16'd34437;
    localparam logic [REG_W-1:0] INSERT_CODES_RST = 16'd23158;
    localparam logic [REG_W-1:0] WAIT_TICKS_RST   = 16'd500;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_W-1:0] {
        CFG_SHIFT  = 3'd0,
        CFG_CTRL   = 3'd1,
        CFG_ALT    = 3'd2,
        CFG_META   = 3'd3,
        CFG_INSERT = 3'd4,
        CFG_WAIT   = 3'd5
    } cfg_idx_t;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_APPEND  = 2'd3
    } req_t;

    // Modifier bit positions.
    localparam logic [MODS_W-1:0] MOD_SHIFT = 4'b0001;
    localparam logic [MODS_W-1:0] MOD_CTRL  = 4'b0010;
    localparam logic [MODS_W-1:0] MOD_ALT   = 4'b0100;
    localparam logic [MODS_W-1:0] MOD_META  = 4'b1000;

    // One hotkey table entry.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  key2;
        logic [MODS_W-1:0] mods;
        logic [HNDL_W-1:0] handle;
    } entry_t;

    // Search request that walks down the row of table cells.
    typedef struct packed {
        logic              vld;
        logic              found;
        logic [KEY_W-1:0]  key;
        logic [MODS_W-1:0] mods;
        logic [KEY_W-1:0]  key2;
        logic [HNDL_W-1:0] handle;
    } query_t;

    // True when the key equals either byte of a left/right code pair.
    function automatic logic code_is(input logic [REG_W-1:0] pair,
                                     input logic [KEY_W-1:0] key);
        code_is = (key == pair[KEY_W-1:0]) || (key == pair[REG_W-1:KEY_W]);
    endfunction

    // Modifier bit of a key; shift wins over ctrl over alt over meta.
    function automatic logic [MODS_W-1:0] mod_bit(input logic [KEY_W-1:0] key,
                                                  input logic [REG_W-1:0] sh,
                                                  input logic [REG_W-1:0] ct,
                                                  input logic [REG_W-1:0] al,
                                                  input logic [REG_W-1:0] me);
        logic [MODS_W-1:0] bits;
        bits = '0;
        priority if (code_is(sh, key)) begin
            bits = MOD_SHIFT;
        end else if (code_is(ct, key)) begin
            bits = MOD_CTRL;
        end else if (code_is(al, key)) begin
            bits = MOD_ALT;
        end else if (code_is(me, key)) begin
            bits = MOD_META;
        end else begin
            bits = '0;
        end
        mod_bit = bits;
    endfunction

endpackage

// ===== rtl/tshm_cell.sv =====
// One hotkey table cell: holds an entry and passes the search request on to the next cell.
`timescale 1ns / 1ps

module tshm_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  count,
    input  logic              wr_en,
    input  tshm_pkg::entry_t  wr_data,
    input  tshm_pkg::query_t  q_in,
    output tshm_pkg::query_t  q_out
);

    tshm_pkg::entry_t entry_reg;
    tshm_pkg::query_t q_reg;
    tshm_pkg::query_t q_next;
    logic             hit;

    // The entry only takes part once the fill count has passed this cell.
    assign hit = (count > CNT_W'(IDX)) && (entry_reg.key == q_in.key)
                 && (entry_reg.mods == q_in.mods);

    always_comb begin
        q_next = q_in;
        if (q_in.vld && !q_in.found && hit) begin
            q_next.found  = 1'b1;
            q_next.key2   = entry_reg.key2;
            q_next.handle = entry_reg.handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.vld <= 1'b0;
        end else begin
            q_reg.vld <= q_next.vld;
        end
        q_reg.found  <= q_next.found;
        q_reg.key    <= q_next.key;
        q_reg.mods   <= q_next.mods;
        q_reg.key2   <= q_next.key2;
        q_reg.handle <= q_next.handle;
    end

    assign q_out = q_reg;

endmodule

// ===== rtl/two_stage_hotkey_matcher.sv =====
// Top level of the two-stage hotkey matcher: control, modifier tracking, wait timer and cell row.
`timescale 1ns / 1ps

// The matcher takes one request at a time: key presses, key releases, timer ticks
// and table appends, and returns exactly one result for each. Releases, ticks,
// appends, modifier presses and presses that complete a pending two-key wait go
// from evaluation straight to the done state. Any other press walks the table:
// the search request moves through a row of TABLE_DEPTH cells, one cell per cycle,
// and its result is taken once the request leaves the last cell. A new request is
// accepted as soon as the previous result has been loaded into the output
// register, even while that result still waits for m_ready. Configuration writes
// take effect at once and are meant to be issued only while the block is idle.
// The hotkey table itself is not cleared by reset; the entry count decides which
// cells take part in a search.
module two_stage_hotkey_matcher #(
    parameter int TABLE_DEPTH = tshm_pkg::TABLE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Configuration write port.
    input  logic                         cfg_we,
    input  logic [tshm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tshm_pkg::REG_W-1:0]   cfg_wdata,

    // Request channel.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [tshm_pkg::KEY_W-1:0]   s_key_code,
    input  logic [tshm_pkg::KEY_W-1:0]   s_entry_key,
    input  logic [tshm_pkg::KEY_W-1:0]   s_entry_second_key,
    input  logic [tshm_pkg::MODS_W-1:0]  s_entry_modifiers,
    input  logic [tshm_pkg::HNDL_W-1:0]  s_entry_handle,

    // Result channel.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_activated,
    output logic [tshm_pkg::HNDL_W-1:0]  m_active_handle,
    output logic                         m_matched,
    output logic                         m_awaiting_second,
    output logic                         m_table_full
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Control states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [tshm_pkg::REG_W-1:0] shift_codes_reg, ctrl_codes_reg, alt_codes_reg;
    logic [tshm_pkg::REG_W-1:0] meta_codes_reg, insert_codes_reg, wait_ticks_reg;

    // The accepted request.
    logic [1:0]                  req_reg;
    logic [tshm_pkg::KEY_W-1:0]  key_reg;
    tshm_pkg::entry_t            ent_reg;

    // Matcher state.
    logic [tshm_pkg::MODS_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        wait_armed_reg, wait_armed_next;
    logic [tshm_pkg::KEY_W-1:0]  wait_key2_reg, wait_key2_next;
    logic [tshm_pkg::MODS_W-1:0] wait_mods_reg, wait_mods_next;
    logic [tshm_pkg::HNDL_W-1:0] wait_handle_reg, wait_handle_next;
    logic [tshm_pkg::REG_W-1:0]  wait_timer_reg, wait_timer_next;

    // Result being assembled.
    logic                        res_act_reg, res_act_next;
    logic [tshm_pkg::HNDL_W-1:0] res_handle_reg, res_handle_next;
    logic                        res_matched_reg, res_matched_next;
    logic                        res_full_reg, res_full_next;

    // Output register.
    logic                        m_valid_reg, m_valid_next;
    logic                        out_act_reg;
    logic [tshm_pkg::HNDL_W-1:0] out_handle_reg;
    logic                        out_matched_reg, out_awaiting_reg, out_full_reg;
    logic                        out_load;

    // Request decode.
    logic [tshm_pkg::MODS_W-1:0] mb;
    logic [tshm_pkg::KEY_W-1:0]  key_mapped;
    logic                        wait_hit;
    logic                        accept;
    logic                        append_ok;

    // Cell row.
    tshm_pkg::query_t            q_head;
    tshm_pkg::query_t            q [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]      cell_we;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Configuration writes. Indexes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_codes_reg  <= tshm_pkg::SHIFT_CODES_RST;
            ctrl_codes_reg   <= tshm_pkg::CTRL_CODES_RST;
            alt_codes_reg    <= tshm_pkg::ALT_CODES_RST;
            meta_codes_reg   <= tshm_pkg::META_CODES_RST;
            insert_codes_reg <= tshm_pkg::INSERT_CODES_RST;
            wait_ticks_reg   <= tshm_pkg::WAIT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (tshm_pkg::cfg_idx_t'(cfg_index))
                tshm_pkg::CFG_SHIFT:  shift_codes_reg  <= cfg_wdata;
                tshm_pkg::CFG_CTRL:   ctrl_codes_reg   <= cfg_wdata;
                tshm_pkg::CFG_ALT:    alt_codes_reg    <= cfg_wdata;
                tshm_pkg::CFG_META:   meta_codes_reg   <= cfg_wdata;
                tshm_pkg::CFG_INSERT: insert_codes_reg <= cfg_wdata;
                tshm_pkg::CFG_WAIT:   wait_ticks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The accepted request is held for the whole of its processing.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg        <= s_req_type;
            key_reg        <= s_key_code;
            ent_reg.key    <= s_entry_key;
            ent_reg.key2   <= s_entry_second_key;
            ent_reg.mods   <= s_entry_modifiers;
            ent_reg.handle <= s_entry_handle;
        end
    end

    // The modifier lookup uses the raw keycode; keypad insert is folded into
    // insert only for matching.
    assign mb = tshm_pkg::mod_bit(key_reg, shift_codes_reg, ctrl_codes_reg,
                                  alt_codes_reg, meta_codes_reg);
    assign key_mapped = (key_reg == insert_codes_reg[tshm_pkg::REG_W-1:tshm_pkg::KEY_W])
                        ? insert_codes_reg[tshm_pkg::KEY_W-1:0] : key_reg;
    assign wait_hit = wait_armed_reg && (wait_key2_reg == key_mapped)
                      && (wait_mods_reg == held_reg);
    assign append_ok = (ent_reg.key != '0) && (count_reg < CNT_W'(TABLE_DEPTH));

    // The search request enters the first cell only when a non-modifier press
    // has missed the pending wait.
    always_comb begin
        q_head        = '0;
        q_head.vld    = (state_reg == ST_EVAL)
                        && (tshm_pkg::req_t'(req_reg) == tshm_pkg::REQ_PRESS)
                        && (mb == '0) && !wait_hit;
        q_head.key    = key_mapped;
        q_head.mods   = held_reg;
    end

    assign q[0] = q_head;

    // A new entry goes into the cell that the fill count points at.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_we[i] = (state_reg == ST_EVAL)
                         && (tshm_pkg::req_t'(req_reg) == tshm_pkg::REQ_APPEND)
                         && append_ok && (count_reg == CNT_W'(i));
        end
    end

    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            tshm_cell #(
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .count   (count_reg),
                .wr_en   (cell_we[g]),
                .wr_data (ent_reg),
                .q_in    (q[g]),
                .q_out   (q[g+1])
            );
        end
    endgenerate

    // Main control: each request is evaluated once, a table search waits for
    // the request to leave the last cell, and the result is then loaded into
    // the output register as soon as that register is free.
    always_comb begin
        state_next       = state_reg;
        held_next        = held_reg;
        count_next       = count_reg;
        wait_armed_next  = wait_armed_reg;
        wait_key2_next   = wait_key2_reg;
        wait_mods_next   = wait_mods_reg;
        wait_handle_next = wait_handle_reg;
        wait_timer_next  = wait_timer_reg;
        res_act_next     = res_act_reg;
        res_handle_next  = res_handle_reg;
        res_matched_next = res_matched_reg;
        res_full_next    = res_full_reg;
        out_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_act_next     = 1'b0;
                res_handle_next  = '0;
                res_matched_next = 1'b0;
                res_full_next    = 1'b0;
                state_next       = ST_DONE;
                unique case (tshm_pkg::req_t'(req_reg))
                    tshm_pkg::REQ_PRESS: begin
                        if (mb != '0) begin
                            held_next = held_reg | mb;
                        end else begin
                            // Any ordinary press cancels the pending wait.
                            wait_armed_next = 1'b0;
                            if (wait_hit) begin
                                res_act_next     = 1'b1;
                                res_handle_next  = wait_handle_reg;
                                res_matched_next = 1'b1;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    tshm_pkg::REQ_RELEASE: begin
                        held_next = held_reg & ~mb;
                    end
                    tshm_pkg::REQ_TICK: begin
                        if (wait_armed_reg) begin
                            if (wait_timer_reg <= tshm_pkg::REG_W'(1)) begin
                                wait_timer_next = '0;
                                wait_armed_next = 1'b0;
                            end else begin
                                wait_timer_next = wait_timer_reg - tshm_pkg::REG_W'(1);
                            end
                        end
                    end
                    tshm_pkg::REQ_APPEND: begin
                        if (ent_reg.key != '0) begin
                            if (append_ok) begin
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                res_full_next = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                if (q[TABLE_DEPTH].vld) begin
                    state_next = ST_DONE;
                    if (q[TABLE_DEPTH].found) begin
                        res_matched_next = 1'b1;
                        if (q[TABLE_DEPTH].key2 == '0) begin
                            res_act_next    = 1'b1;
                            res_handle_next = q[TABLE_DEPTH].handle;
                        end else begin
                            // A two-key entry arms a fresh wait of full length.
                            wait_armed_next  = 1'b1;
                            wait_key2_next   = q[TABLE_DEPTH].key2;
                            wait_mods_next   = q[TABLE_DEPTH].mods;
                            wait_handle_next = q[TABLE_DEPTH].handle;
                            wait_timer_next  = wait_ticks_reg;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            held_reg        <= '0;
            count_reg       <= '0;
            wait_armed_reg  <= 1'b0;
            wait_key2_reg   <= '0;
            wait_mods_reg   <= '0;
            wait_handle_reg <= '0;
            wait_timer_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            held_reg        <= held_next;
            count_reg       <= count_next;
            wait_armed_reg  <= wait_armed_next;
            wait_key2_reg   <= wait_key2_next;
            wait_mods_reg   <= wait_mods_next;
            wait_handle_reg <= wait_handle_next;
            wait_timer_reg  <= wait_timer_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_act_reg     <= res_act_next;
        res_handle_reg  <= res_handle_next;
        res_matched_reg <= res_matched_next;
        res_full_reg    <= res_full_next;
        // The wait flag is final by the time the result is loaded.
        if (out_load) begin
            out_act_reg      <= res_act_reg;
            out_handle_reg   <= res_handle_reg;
            out_matched_reg  <= res_matched_reg;
            out_awaiting_reg <= wait_armed_reg;
            out_full_reg     <= res_full_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_activated       = out_act_reg;
    assign m_active_handle   = out_handle_reg;
    assign m_matched         = out_matched_reg;
    assign m_awaiting_second = out_awaiting_reg;
    assign m_table_full      = out_full_reg;

endmodule

// ===== rtl/tshm_checker.sv =====
// Port-level checker of the two-stage hotkey matcher and its bind statement.
`timescale 1ns / 1ps

module tshm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_activated,
    input logic [tshm_pkg::HNDL_W-1:0]  m_active_handle,
    input logic                         m_matched,
    input logic                         m_awaiting_second,
    input logic                         m_table_full
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_activated)
        && $stable(m_active_handle) && $stable(m_matched)
        && $stable(m_awaiting_second) && $stable(m_table_full))
        else $error("result changed while stalled");

    // Only one request is in flight: after an acceptance the input closes.
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // An activation is always a match.
    a_act_matched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_activated |-> m_matched)
        else $error("activation without a match");

    // The handle is zero unless a hotkey activated.
    a_handle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_activated |-> m_active_handle == '0)
        else $error("handle reported without activation");

    // A refused append is never a key match.
    a_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> !m_matched && !m_activated)
        else $error("table full reported on a press");

endmodule

bind two_stage_hotkey_matcher tshm_checker u_tshm_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_activated       (m_activated),
    .m_active_handle   (m_active_handle),
    .m_matched         (m_matched),
    .m_awaiting_second (m_awaiting_second),
    .m_table_full      (m_table_full)
);
